FILE: src/tsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared constants, types and helpers of the tile and sprite pixel renderer.
// ----------------------------------------------------------------------------
package tsr_pkg;

	// screen and sprite limits
	localparam int SCREEN_COLUMNS   = 160;
	localparam int SPRITES_PER_LINE = 10;
	localparam int SPRITE_ENTRIES   = 40;
	localparam int SPRITE_SLOTS     = 40;   // entries held by the attribute table
	localparam int SLOT_W           = 6;
	localparam int WINDOW_LEFT_MAX  = 166;
	localparam int WINDOW_ROWS      = 144;

	// store geometry: patterns are split into even and odd byte halves
	localparam int PAT_WORDS = 3072;
	localparam int PAT_AW    = 12;
	localparam int MAP_BYTES = 2048;
	localparam int MAP_AW    = 11;

	// command codes
	localparam logic [1:0] CMD_READ   = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_RENDER = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_LOCKED  = 2'd1;
	localparam logic [1:0] STAT_BADADDR = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_LCD_CONTROL = 3'd0;
	localparam logic [2:0] REG_SCROLL_Y    = 3'd1;
	localparam logic [2:0] REG_SCROLL_X    = 3'd2;
	localparam logic [2:0] REG_WINDOW_TOP  = 3'd3;
	localparam logic [2:0] REG_WINDOW_LEFT = 3'd4;
	localparam logic [2:0] REG_BG_PAL      = 3'd5;
	localparam logic [2:0] REG_OBJ_PAL0    = 3'd6;
	localparam logic [2:0] REG_OBJ_PAL1    = 3'd7;

	// byte positions inside a sprite entry
	localparam int SPR_Y    = 0;
	localparam int SPR_X    = 1;
	localparam int SPR_TILE = 2;
	localparam int SPR_ATTR = 3;

	typedef logic [3:0][7:0] spr_entry_t;

	typedef enum logic [1:0] {
		REGION_NONE,
		REGION_TILE,
		REGION_MAP,
		REGION_SPR
	} region_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BUS,
		ST_BUSRD,
		ST_ROT,
		ST_SPR,
		ST_SFETCH,
		ST_SPREND,
		ST_SEL,
		ST_MAP,
		ST_MAPW,
		ST_PATW,
		ST_DONE
	} state_t;

	// sprite test result for the entry at the head of the chain
	typedef struct packed {
		logic        online;
		logic        xhit;
		logic [10:0] word;
		logic [2:0]  col;
		logic        pal_one;
		logic        behind;
	} spr_eval_t;

	function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] ci);
		logic [1:0] s;
		case (ci)
			2'd0:    s = pal[1:0];
			2'd1:    s = pal[3:2];
			2'd2:    s = pal[5:4];
			default: s = pal[7:6];
		endcase
		return s;
	endfunction

endpackage

FILE: src/tsr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_cell
// One sprite attribute entry; takes its neighbor's entry when the chain moves.
// ----------------------------------------------------------------------------
module tsr_cell import tsr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  spr_entry_t din,
	output spr_entry_t dout
);

	spr_entry_t entry_q;

	// entry register, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

FILE: src/tsr_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_eval
// Line and column test of one sprite entry and its pattern word address.
// ----------------------------------------------------------------------------
module tsr_eval import tsr_pkg::*; (
	input  spr_entry_t entry,
	input  logic [7:0] px,
	input  logic [7:0] py,
	input  logic       tall,
	output spr_eval_t  ev
);

	logic [9:0] py16, px8, sy, sx, height, tx, ty;
	logic [2:0] txf;
	logic [3:0] tyf;
	logic [7:0] tile;

	always_comb begin
		py16   = {2'b00, py} + 10'd16;
		px8    = {2'b00, px} + 10'd8;
		sy     = {2'b00, entry[SPR_Y]};
		sx     = {2'b00, entry[SPR_X]};
		height = tall ? 10'd16 : 10'd8;
		tx     = px8 - sx;
		ty     = py16 - sy;

		// flips
		txf = entry[SPR_ATTR][5] ? ~tx[2:0] : tx[2:0];
		if (entry[SPR_ATTR][6]) begin
			tyf = tall ? ~ty[3:0] : {1'b0, ~ty[2:0]};
		end else begin
			tyf = ty[3:0];
		end

		// tall sprites use the tile pair
		tile = tall ? {entry[SPR_TILE][7:1], tyf[3]} : entry[SPR_TILE];

		ev.online  = (sy <= py16) && (py16 < sy + height);
		ev.xhit    = (sx <= px8) && (sx > {2'b00, px});
		ev.word    = {tile, tyf[2:0]};
		ev.col     = txf;
		ev.pal_one = entry[SPR_ATTR][4];
		ev.behind  = entry[SPR_ATTR][7];
	end

endmodule

FILE: src/tile_sprite_pixel_renderer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_sprite_pixel_renderer_top
// Video stores with byte access and a one-pixel tile and sprite renderer.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the pattern and map
// memories with busy high; configuration writes are taken throughout.
// A request is taken when start is high and busy is low, and its result shows
// for exactly one cycle with done high; the receiver cannot stall it. A tile
// or map byte access passes through a bus state and a read state; a sprite
// table byte access rotates the 40-entry table once through its chain of cells.
// A render rotates the sprite chain when sprites are on, with one pattern
// fetch per candidate sprite (at most 10) on the single pattern memory port,
// and then, if needed, fetches the map and then the pattern entry. Unknown
// commands, bad addresses and locked accesses go straight to done.
// ----------------------------------------------------------------------------
module tile_sprite_pixel_renderer_top import tsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic        from_dma,
	input  logic [1:0]  lcd_mode,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic        new_frame,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic [7:0]  read_data,
	output logic [1:0]  shade,
	output logic [1:0]  status
);

	state_t state_q, state_d;

	// configuration
	logic [7:0] lcdc_q, scy_q, scx_q, wtop_q, wleft_q, bgp_q, obp0_q, obp1_q;

	// request registers
	logic [1:0]  cmd_q;
	logic [12:0] off_q;
	logic [7:0]  wdata_q, px_q, py_q;
	region_t     region_q;
	logic [7:0]  win_line_q;

	// result registers
	logic [7:0] rdata_q;
	logic [1:0] shade_q, status_q;

	// render state
	logic [SLOT_W-1:0] step_q;
	logic [SLOT_W-1:0] found_q, found_d;
	logic              won_q, front_q;
	logic [7:0]        mx_q, my_q;
	logic              map_hi_q, is_win_q;
	logic [11:0]       clr_q;

	// memories
	logic [7:0] pat_lo_mem [PAT_WORDS];
	logic [7:0] pat_hi_mem [PAT_WORDS];
	logic [7:0] map_mem [MAP_BYTES];
	logic [7:0] pat_lo_rd_q, pat_hi_rd_q, map_rd_q;
	logic [PAT_AW-1:0] pat_addr;
	logic [MAP_AW-1:0] map_addr;
	logic              pat_we_lo, pat_we_hi, map_we;
	logic [7:0]        mem_wd;

	// sprite chain
	spr_entry_t chain [SPRITE_SLOTS];
	spr_entry_t head, tail_in;
	logic       shift;
	spr_eval_t  ev;
	logic       cand, in_scan;
	logic [1:0] spr_ci, bg_ci;
	logic [8:0] tile_idx;

	// request decode
	region_t    region_d;
	logic [1:0] status_d;
	logic       lock_d;

	// window test
	logic [9:0] wx;
	logic [8:0] wy;
	logic       win_ok;
	logic       accept;

	assign accept = (state_q == ST_IDLE) && start;

	// ------------------------------------------------------------------
	// sprite table as a chain of cells, rotating toward the head
	// ------------------------------------------------------------------
	genvar g;
	generate
		for (g = 0; g < SPRITE_SLOTS; g++) begin : g_cell
			if (g == SPRITE_SLOTS - 1) begin : g_tail
				tsr_cell u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift),
					.din(tail_in), .dout(chain[g])
				);
			end else begin : g_body
				tsr_cell u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift),
					.din(chain[g+1]), .dout(chain[g])
				);
			end
		end
	endgenerate

	assign head = chain[0];

	tsr_eval u_eval (
		.entry(head), .px(px_q), .py(py_q), .tall(lcdc_q[2]), .ev(ev)
	);

	// sprite search at the head
	always_comb begin
		in_scan = step_q < SLOT_W'(SPRITE_ENTRIES);
		found_d = found_q + SLOT_W'(ev.online && in_scan);
		cand    = in_scan && ev.online && (found_d <= SLOT_W'(SPRITES_PER_LINE))
		          && ev.xhit && !won_q;
		spr_ci  = {pat_hi_rd_q[~ev.col], pat_lo_rd_q[~ev.col]};
		bg_ci   = {pat_hi_rd_q[~mx_q[2:0]], pat_lo_rd_q[~mx_q[2:0]]};
	end

	// window coverage
	always_comb begin
		wx     = {2'b00, px_q} - {2'b00, wleft_q} + 10'd7;
		wy     = {1'b0, win_line_q} - {1'b0, wtop_q};
		win_ok = lcdc_q[5] && (wleft_q <= 8'(WINDOW_LEFT_MAX)) && !wx[9]
		         && (wx < 10'(SCREEN_COLUMNS)) && !wy[8] && (wy < 9'(WINDOW_ROWS));
	end

	// map entry to tile index, signed addressing lands at 0x100
	always_comb begin
		if (lcdc_q[4] || map_rd_q[7]) begin
			tile_idx = {1'b0, map_rd_q};
		end else begin
			tile_idx = {1'b1, map_rd_q};
		end
	end

	// request decode at accept
	always_comb begin
		if (address[15:13] == 3'b100 && address[12:11] != 2'b11) begin
			region_d = REGION_TILE;
		end else if (address[15:11] == 5'b10011) begin
			region_d = REGION_MAP;
		end else if (address[15:8] == 8'hFE && address[7:0] < 8'hA0) begin
			region_d = REGION_SPR;
		end else begin
			region_d = REGION_NONE;
		end
		lock_d = !from_dma && ((region_d == REGION_SPR) ? lcd_mode[1] : (lcd_mode == 2'd3));
		if (region_d == REGION_NONE) begin
			status_d = STAT_BADADDR;
		end else if (lock_d) begin
			status_d = STAT_LOCKED;
		end else begin
			status_d = STAT_OK;
		end
	end

	// ------------------------------------------------------------------
	// state register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory controls and chain movement
	always_comb begin
		state_d   = state_q;
		pat_addr  = '0;
		map_addr  = '0;
		pat_we_lo = 1'b0;
		pat_we_hi = 1'b0;
		map_we    = 1'b0;
		mem_wd    = wdata_q;
		shift     = 1'b0;
		tail_in   = head;
		case (state_q)
			ST_CLEAR: begin
				pat_addr  = clr_q;
				map_addr  = clr_q[MAP_AW-1:0];
				pat_we_lo = 1'b1;
				pat_we_hi = 1'b1;
				map_we    = clr_q < 12'(MAP_BYTES);
				mem_wd    = 8'd0;
				if (clr_q == 12'(PAT_WORDS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_READ || command == CMD_WRITE) begin
						if (status_d != STAT_OK) begin
							state_d = ST_DONE;
						end else if (region_d == REGION_SPR) begin
							state_d = ST_ROT;
						end else begin
							state_d = ST_BUS;
						end
					end else if (command == CMD_RENDER) begin
						state_d = lcdc_q[1] ? ST_SPR : ST_SEL;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_BUS: begin
				pat_addr = off_q[12:1];
				map_addr = off_q[MAP_AW-1:0];
				if (cmd_q == CMD_WRITE) begin
					pat_we_lo = (region_q == REGION_TILE) && !off_q[0];
					pat_we_hi = (region_q == REGION_TILE) && off_q[0];
					map_we    = (region_q == REGION_MAP);
				end
				state_d = ST_BUSRD;
			end
			ST_BUSRD: state_d = ST_DONE;
			ST_ROT: begin
				shift = 1'b1;
				if (step_q == off_q[7:2] && cmd_q == CMD_WRITE) begin
					tail_in[off_q[1:0]] = wdata_q;
				end
				if (step_q == SLOT_W'(SPRITE_SLOTS - 1)) state_d = ST_DONE;
			end
			ST_SPR: begin
				pat_addr = {1'b0, ev.word};
				if (cand) begin
					state_d = ST_SFETCH;
				end else begin
					shift = 1'b1;
					if (step_q == SLOT_W'(SPRITE_SLOTS - 1)) state_d = ST_SPREND;
				end
			end
			ST_SFETCH: begin
				shift = 1'b1;
				state_d = (step_q == SLOT_W'(SPRITE_SLOTS - 1)) ? ST_SPREND : ST_SPR;
			end
			ST_SPREND: state_d = (won_q && front_q) ? ST_DONE : ST_SEL;
			ST_SEL: state_d = (win_ok || lcdc_q[0]) ? ST_MAP : ST_DONE;
			ST_MAP: begin
				map_addr = {map_hi_q, my_q[7:3], mx_q[7:3]};
				state_d  = ST_MAPW;
			end
			ST_MAPW: begin
				pat_addr = {tile_idx, my_q[2:0]};
				state_d  = ST_PATW;
			end
			ST_PATW: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// memories
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (pat_we_lo) pat_lo_mem[pat_addr] <= mem_wd;
		pat_lo_rd_q <= pat_lo_mem[pat_addr];
	end

	always_ff @(posedge clk) begin
		if (pat_we_hi) pat_hi_mem[pat_addr] <= mem_wd;
		pat_hi_rd_q <= pat_hi_mem[pat_addr];
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_addr] <= mem_wd;
		map_rd_q <= map_mem[map_addr];
	end

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcdc_q  <= '0;
			scy_q   <= '0;
			scx_q   <= '0;
			wtop_q  <= '0;
			wleft_q <= '0;
			bgp_q   <= '0;
			obp0_q  <= '0;
			obp1_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LCD_CONTROL: lcdc_q  <= cfg_data;
				REG_SCROLL_Y:    scy_q   <= cfg_data;
				REG_SCROLL_X:    scx_q   <= cfg_data;
				REG_WINDOW_TOP:  wtop_q  <= cfg_data;
				REG_WINDOW_LEFT: wleft_q <= cfg_data;
				REG_BG_PAL:      bgp_q   <= cfg_data;
				REG_OBJ_PAL0:    obp0_q  <= cfg_data;
				REG_OBJ_PAL1:    obp1_q  <= cfg_data;
				default:         lcdc_q  <= lcdc_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// control counters and window line
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			step_q     <= '0;
			found_q    <= '0;
			won_q      <= 1'b0;
			front_q    <= 1'b0;
			win_line_q <= '0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + 12'd1;
			if (accept) begin
				step_q  <= '0;
				found_q <= '0;
				won_q   <= 1'b0;
				front_q <= 1'b0;
				if (new_frame) win_line_q <= '0;
			end else begin
				if (shift) step_q <= step_q + SLOT_W'(1);
				if (shift) found_q <= found_d;
				if (state_q == ST_SFETCH && spr_ci != 2'd0) begin
					won_q   <= 1'b1;
					front_q <= !ev.behind;
				end
				// line counter moves after the last column
				if (state_q == ST_DONE && cmd_q == CMD_RENDER
				    && px_q == 8'(SCREEN_COLUMNS - 1)
				    && (wleft_q <= 8'(WINDOW_LEFT_MAX) || lcdc_q[5])) begin
					win_line_q <= win_line_q + 8'd1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// request and result datapath
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= command;
			off_q    <= address[12:0];
			wdata_q  <= write_data;
			px_q     <= pixel_x;
			py_q     <= pixel_y;
			region_q <= region_d;
			rdata_q  <= '0;
			shade_q  <= '0;
			status_q <= (command == CMD_READ || command == CMD_WRITE) ? status_d : STAT_OK;
		end else begin
			case (state_q)
				ST_BUSRD: begin
					if (cmd_q == CMD_READ) begin
						if (region_q == REGION_MAP) begin
							rdata_q <= map_rd_q;
						end else begin
							rdata_q <= off_q[0] ? pat_hi_rd_q : pat_lo_rd_q;
						end
					end
				end
				ST_ROT: begin
					if (step_q == off_q[7:2] && cmd_q == CMD_READ) begin
						rdata_q <= head[off_q[1:0]];
					end
				end
				ST_SFETCH: begin
					if (spr_ci != 2'd0) begin
						shade_q <= pal_shade(ev.pal_one ? obp1_q : obp0_q, spr_ci);
					end
				end
				ST_SEL: begin
					if (win_ok) begin
						mx_q     <= wx[7:0];
						my_q     <= wy[7:0];
						map_hi_q <= lcdc_q[6];
						is_win_q <= 1'b1;
					end else begin
						mx_q     <= px_q + scx_q;
						my_q     <= py_q + scy_q;
						map_hi_q <= lcdc_q[3];
						is_win_q <= 1'b0;
					end
				end
				ST_PATW: begin
					// window always wins; background only when nonzero
					if (is_win_q || pal_shade(bgp_q, bg_ci) != 2'd0) begin
						shade_q <= pal_shade(bgp_q, bg_ci);
					end
				end
				default: rdata_q <= rdata_q;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = (state_q == ST_DONE);
	assign read_data = rdata_q;
	assign shade     = shade_q;
	assign status    = status_q;

endmodule
